// ===== sv/sd_spi_init_sequencer_macros.svh =====
// ----------------------------------------------------------------------------
// sd_spi_init_sequencer assertion macros
// shared property forms for the sd spi init sequencer checks
// ----------------------------------------------------------------------------
`ifndef SD_SPI_INIT_SEQUENCER_MACROS_SVH
`define SD_SPI_INIT_SEQUENCER_MACROS_SVH

// same-cycle implication, disabled during reset
`define SDSI_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define SDSI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/sdsi_pkg.sv =====
// ----------------------------------------------------------------------------
// sdsi_pkg
// types, codes and constants of the sd card spi-mode init sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package sdsi_pkg;

   // request codes
   localparam logic [1:0] REQ_START = 2'd0;
   localparam logic [1:0] REQ_BYTE  = 2'd1;
   localparam logic [1:0] REQ_DELAY = 2'd2;

   // completion status codes
   localparam logic [1:0] STATUS_OK            = 2'd0;
   localparam logic [1:0] STATUS_CMD0_TIMEOUT  = 2'd1;
   localparam logic [1:0] STATUS_CMD1_TIMEOUT  = 2'd2;

   // csr indexes
   localparam logic [1:0] CSR_RETRY_LIMIT      = 2'd0;
   localparam logic [1:0] CSR_INIT_CLOCK_BYTES = 2'd1;
   localparam logic [1:0] CSR_BLOCK_LENGTH     = 2'd2;
   localparam logic [1:0] CSR_ACMD41_ARGUMENT  = 2'd3;

   // csr reset values
   localparam logic [7:0]  RETRY_LIMIT_RST      = 8'd100;
   localparam logic [7:0]  INIT_CLOCK_BYTES_RST = 8'd10;
   localparam logic [31:0] BLOCK_LENGTH_RST     = 32'h0000_0200;
   localparam logic [31:0] ACMD41_ARGUMENT_RST  = 32'h4000_0000;

   // command bytes and spi constants
   localparam logic [7:0] CMD0_BYTE   = 8'h40;
   localparam logic [7:0] CMD8_BYTE   = 8'h48;
   localparam logic [7:0] CMD55_BYTE  = 8'h77;
   localparam logic [7:0] CMD41_BYTE  = 8'h69;
   localparam logic [7:0] CMD1_BYTE   = 8'h41;
   localparam logic [7:0] CMD16_BYTE  = 8'h50;
   localparam logic [7:0] CMD0_CRC    = 8'h95;
   localparam logic [7:0] FILL_BYTE   = 8'hFF;
   localparam logic [7:0] R1_IDLE     = 8'h01;
   localparam logic [7:0] R1_READY    = 8'h00;

   // frame layout: command, four argument bytes, crc, then the read window
   localparam int unsigned RESPONSE_WINDOW = 8;
   localparam logic [7:0]  FRAME_HEAD      = 8'd6;
   localparam logic [7:0]  FRAME_LEN       = 8'(6 + RESPONSE_WINDOW);

   typedef enum logic [11:0] {
      PH_IDLE   = 12'b0000_0000_0001,
      PH_CLOCKS = 12'b0000_0000_0010,
      PH_CMD0   = 12'b0000_0000_0100,
      PH_CMD8   = 12'b0000_0000_1000,
      PH_CMD55  = 12'b0000_0001_0000,
      PH_CMD41  = 12'b0000_0010_0000,
      PH_CMD1   = 12'b0000_0100_0000,
      PH_CMD16  = 12'b0000_1000_0000,
      PH_WAIT0  = 12'b0001_0000_0000,
      PH_WAIT8  = 12'b0010_0000_0000,
      PH_WAIT41 = 12'b0100_0000_0000,
      PH_WAIT1  = 12'b1000_0000_0000
   } sdsi_phase_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] rx_byte;
   } sdsi_req_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       select_active;
      logic       wait_delay;
      logic       done_res;
      logic [1:0] status;
      logic [7:0] final_response;
   } sdsi_rsp_type;

   typedef struct packed {
      logic [7:0]  retry_limit;
      logic [7:0]  init_clock_bytes;
      logic [31:0] block_length;
      logic [31:0] acmd41_argument;
   } sdsi_cfg_type;

   typedef struct packed {
      sdsi_phase_type phase;
      logic [7:0]     byte_count;
      logic [7:0]     try_count;
      logic [7:0]     found_response;
      logic           response_seen;
   } sdsi_state_type;

   localparam sdsi_state_type STATE_RST = '{
      phase:          PH_IDLE,
      byte_count:     8'd0,
      try_count:      8'd0,
      found_response: FILL_BYTE,
      response_seen:  1'b0
   };

endpackage

`default_nettype wire

// ===== sv/sdsi_csr.sv =====
// ----------------------------------------------------------------------------
// sdsi_csr
// configuration registers of the init sequencer, write-only
// ----------------------------------------------------------------------------
`default_nettype none

module sdsi_csr
   import sdsi_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_index,
   input  wire logic [31:0]  csr_wdata,
   output sdsi_cfg_type      cfg
);

   sdsi_cfg_type cfg_ff;
   sdsi_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_RETRY_LIMIT:      cfg_in.retry_limit      = csr_wdata[7:0];
            CSR_INIT_CLOCK_BYTES: cfg_in.init_clock_bytes = csr_wdata[7:0];
            CSR_BLOCK_LENGTH:     cfg_in.block_length     = csr_wdata;
            CSR_ACMD41_ARGUMENT:  cfg_in.acmd41_argument  = csr_wdata;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.retry_limit      <= RETRY_LIMIT_RST;
         cfg_ff.init_clock_bytes <= INIT_CLOCK_BYTES_RST;
         cfg_ff.block_length     <= BLOCK_LENGTH_RST;
         cfg_ff.acmd41_argument  <= ACMD41_ARGUMENT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== sv/sdsi_core.sv =====
// ----------------------------------------------------------------------------
// sdsi_core
// next-state and result logic for one transaction of the init sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module sdsi_core
   import sdsi_pkg::*;
#(
   parameter int unsigned RESPONSE_WINDOW = sdsi_pkg::RESPONSE_WINDOW
)
(
   input  wire sdsi_req_type   req,
   input  wire sdsi_state_type st,
   input  wire sdsi_cfg_type   cfg,
   output sdsi_state_type      st_nxt,
   output sdsi_rsp_type        rsp
);

   // command head plus the read window
   localparam logic [7:0] FRAME_END = 8'(FRAME_HEAD + RESPONSE_WINDOW);

   // byte idx of the frame sent in phase ph
   function automatic logic [7:0] frame_byte(sdsi_phase_type ph, logic [7:0] idx,
                                             sdsi_cfg_type c);
      logic [7:0]  cmd;
      logic [31:0] arg;
      logic [7:0]  crc;
      logic [7:0]  res;
      cmd = FILL_BYTE;
      arg = 32'd0;
      crc = FILL_BYTE;
      case (ph)
         PH_CMD0:  begin
            cmd = CMD0_BYTE;
            crc = CMD0_CRC;
         end
         PH_CMD8:  cmd = CMD8_BYTE;
         PH_CMD55: cmd = CMD55_BYTE;
         PH_CMD41: begin
            cmd = CMD41_BYTE;
            arg = c.acmd41_argument;
         end
         PH_CMD1:  cmd = CMD1_BYTE;
         PH_CMD16: begin
            cmd = CMD16_BYTE;
            arg = c.block_length;
         end
         default:  cmd = FILL_BYTE;
      endcase
      case (idx)
         8'd0:    res = cmd;
         8'd1:    res = arg[31:24];
         8'd2:    res = arg[23:16];
         8'd3:    res = arg[15:8];
         8'd4:    res = arg[7:0];
         8'd5:    res = crc;
         default: res = FILL_BYTE;
      endcase
      return res;
   endfunction

   logic           exhausted;
   logic [7:0]     bc_inc;
   logic [7:0]     resp;
   logic           do_start;
   sdsi_phase_type start_ph;
   logic           clr_try;
   logic           do_finish;
   logic [1:0]     fin_status;
   logic           do_fail;
   sdsi_phase_type fail_ph;

   assign exhausted = st.try_count >= cfg.retry_limit;
   assign bc_inc    = 8'(st.byte_count + 8'd1);

   always_comb begin
      st_nxt     = st;
      rsp        = '0;
      resp       = st.found_response;
      do_start   = 1'b0;
      start_ph   = PH_IDLE;
      clr_try    = 1'b0;
      do_finish  = 1'b0;
      fin_status = STATUS_OK;
      do_fail    = 1'b0;
      fail_ph    = PH_IDLE;

      case (req.req_type)
         REQ_START: begin
            st_nxt            = STATE_RST;
            st_nxt.phase      = PH_CLOCKS;
            rsp.tx_valid      = 1'b1;
            rsp.tx_byte       = FILL_BYTE;
         end
         REQ_DELAY: begin
            case (st.phase)
               PH_WAIT0: begin
                  if (exhausted) begin
                     do_finish  = 1'b1;
                     fin_status = STATUS_CMD0_TIMEOUT;
                  end else begin
                     do_start = 1'b1;
                     start_ph = PH_CMD0;
                  end
               end
               PH_WAIT8: begin
                  do_start = 1'b1;
                  clr_try  = exhausted;
                  start_ph = exhausted ? PH_CMD55 : PH_CMD8;
               end
               PH_WAIT41: begin
                  do_start = 1'b1;
                  clr_try  = exhausted;
                  start_ph = exhausted ? PH_CMD1 : PH_CMD55;
               end
               PH_WAIT1: begin
                  if (exhausted) begin
                     do_finish  = 1'b1;
                     fin_status = STATUS_CMD1_TIMEOUT;
                  end else begin
                     do_start = 1'b1;
                     start_ph = PH_CMD1;
                  end
               end
               default: do_start = 1'b0;
            endcase
         end
         REQ_BYTE: begin
            if (st.phase == PH_CLOCKS) begin
               st_nxt.byte_count = bc_inc;
               if (bc_inc >= cfg.init_clock_bytes) begin
                  clr_try  = 1'b1;
                  do_start = 1'b1;
                  start_ph = PH_CMD0;
               end else begin
                  rsp.tx_valid = 1'b1;
                  rsp.tx_byte  = FILL_BYTE;
               end
            end else if (st.phase inside {PH_CMD0, PH_CMD8, PH_CMD55, PH_CMD41,
                                          PH_CMD1, PH_CMD16}) begin
               // first non-fill byte in the read window is the response
               if (st.byte_count >= FRAME_HEAD && !st.response_seen &&
                   req.rx_byte != FILL_BYTE) begin
                  resp                 = req.rx_byte;
                  st_nxt.found_response = req.rx_byte;
                  st_nxt.response_seen  = 1'b1;
               end
               st_nxt.byte_count = bc_inc;
               if (bc_inc < FRAME_END) begin
                  rsp.tx_valid      = 1'b1;
                  rsp.tx_byte       = frame_byte(st.phase, bc_inc, cfg);
                  rsp.select_active = 1'b1;
               end else begin
                  case (st.phase)
                     PH_CMD0: begin
                        if (resp == R1_IDLE) begin
                           clr_try  = 1'b1;
                           do_start = 1'b1;
                           start_ph = PH_CMD8;
                        end else begin
                           do_fail = 1'b1;
                           fail_ph = PH_WAIT0;
                        end
                     end
                     PH_CMD8: begin
                        if (resp != FILL_BYTE) begin
                           clr_try  = 1'b1;
                           do_start = 1'b1;
                           start_ph = PH_CMD55;
                        end else begin
                           do_fail = 1'b1;
                           fail_ph = PH_WAIT8;
                        end
                     end
                     PH_CMD55: begin
                        do_start = 1'b1;
                        start_ph = PH_CMD41;
                     end
                     PH_CMD41: begin
                        if (resp == R1_READY) begin
                           clr_try  = 1'b1;
                           do_start = 1'b1;
                           start_ph = PH_CMD1;
                        end else begin
                           do_fail = 1'b1;
                           fail_ph = PH_WAIT41;
                        end
                     end
                     PH_CMD1: begin
                        if (resp == R1_READY) begin
                           clr_try  = 1'b1;
                           do_start = 1'b1;
                           start_ph = PH_CMD16;
                        end else begin
                           do_fail = 1'b1;
                           fail_ph = PH_WAIT1;
                        end
                     end
                     default: begin
                        do_finish  = 1'b1;
                        fin_status = STATUS_OK;
                     end
                  endcase
               end
            end
         end
         default: st_nxt = st;
      endcase

      if (clr_try) begin
         st_nxt.try_count = 8'd0;
      end
      if (do_start) begin
         st_nxt.phase          = start_ph;
         st_nxt.byte_count     = 8'd0;
         st_nxt.response_seen  = 1'b0;
         st_nxt.found_response = FILL_BYTE;
         rsp.tx_valid          = 1'b1;
         rsp.tx_byte           = frame_byte(start_ph, 8'd0, cfg);
         rsp.select_active     = 1'b1;
      end
      if (do_finish) begin
         st_nxt.phase       = PH_IDLE;
         rsp.done_res       = 1'b1;
         rsp.status         = fin_status;
         rsp.final_response = resp;
      end
      if (do_fail) begin
         st_nxt.try_count = 8'(st.try_count + 8'd1);
         st_nxt.phase     = fail_ph;
         rsp.wait_delay   = 1'b1;
      end
   end

endmodule

`default_nettype wire

// ===== sv/sd_spi_init_sequencer.sv =====
// ----------------------------------------------------------------------------
// sd_spi_init_sequencer
// master-side controller that brings an sd card into spi mode
// ----------------------------------------------------------------------------
// Each request transaction is one event: start, a byte exchanged on the spi
// bus (with the byte shifted in), or the end of a retry delay. Every request
// gives exactly one response transaction telling the spi engine which byte to
// shift next and whether chip select is low, or asking for a retry delay, or
// reporting the end of the sequence with its status and the last command
// response. The block is one register stage in, one stage of decode logic and
// one register stage out: a request is held in the input register until the
// output register can take its response, and a new request is taken every
// cycle as long as the response side keeps up (the output register is the
// only thing that throttles input). In a system the rate is set by the spi
// exchange. The read window after each command frame is RESPONSE_WINDOW
// bytes long. The user must write configuration through the csr port only
// while no transaction is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sd_spi_init_sequencer_macros.svh"

module sd_spi_init_sequencer
   import sdsi_pkg::*;
#(
   parameter int unsigned RESPONSE_WINDOW = sdsi_pkg::RESPONSE_WINDOW
)
(
   input  wire logic         clock,
   input  wire logic         reset,
   // request channel
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire sdsi_req_type req_data,
   // response channel
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output sdsi_rsp_type      rsp_data,
   // configuration writes
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_index,
   input  wire logic [31:0]  csr_wdata
);

   // input register
   logic           in_valid_ff;
   logic           in_valid_in;
   sdsi_req_type   in_data_ff;

   // sequencer state
   sdsi_state_type state_ff;
   sdsi_state_type state_in;

   // output register
   logic           out_valid_ff;
   logic           out_valid_in;
   sdsi_rsp_type   out_data_ff;

   sdsi_cfg_type   cfg;
   sdsi_rsp_type   step_rsp;
   logic           step_fire;
   logic           req_fire;

   // terms used by the checks
   logic           step_wait;
   logic           step_done;
   logic           step_desel;
   logic           parked;
   logic           seq_idle;
   logic           in_clocks;

   sdsi_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sdsi_core #(
      .RESPONSE_WINDOW (RESPONSE_WINDOW)
   ) u_core (
      .req    (in_data_ff),
      .st     (state_ff),
      .cfg    (cfg),
      .st_nxt (state_in),
      .rsp    (step_rsp)
   );

   // a held request is processed once the output register can take the result
   assign step_fire = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step_fire;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (step_fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (step_fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_RST;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (step_fire) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_data;
      end
      if (step_fire) begin
         out_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // checks

   assign step_wait  = step_fire && step_rsp.wait_delay;
   assign step_done  = step_fire && step_rsp.done_res;
   assign step_desel = step_fire && step_rsp.tx_valid && !step_rsp.select_active;
   assign parked     = state_ff.phase inside {PH_WAIT0, PH_WAIT8, PH_WAIT41, PH_WAIT1};
   assign seq_idle   = state_ff.phase == PH_IDLE;
   assign in_clocks  = state_ff.phase == PH_CLOCKS;

   // a response loaded means the output register is full next cycle
   `SDSI_ASSERT_NEXT(a_out_loaded, clock, reset, step_fire, out_valid_ff, "response lost")

   // a response asking for a retry delay parks the sequencer in a wait phase
   `SDSI_ASSERT_NEXT(a_wait_phase, clock, reset, step_wait, parked, "delay outside a wait phase")

   // completion returns the sequencer to idle
   `SDSI_ASSERT_NEXT(a_done_idle, clock, reset, step_done, seq_idle, "done without going idle")

   // bytes with select high only come from the clock phase
   `SDSI_ASSERT_NEXT(a_clk_bytes, clock, reset, step_desel, in_clocks, "stray deselected byte")

endmodule

`default_nettype wire
